FILE: rtl/audio_frame_sync_finder_defines.svh
// ----------------------------------------------------------------------------
// audio_frame_sync_finder_defines
// assertion macros shared by the frame sync finder modules
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_SYNC_FINDER_DEFINES_SVH
`define AUDIO_FRAME_SYNC_FINDER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define AFSF_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AFSF_ASSERT_THEN(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/afsf_pkg.sv
// ----------------------------------------------------------------------------
// afsf_pkg
// shared constants, the job record and lookup tables of the frame sync finder
// ----------------------------------------------------------------------------
package afsf_pkg;

  // default width of buffer positions
  localparam int OFFSET_WIDTH_DEF = 24;

  // job queue between scanner and length unit
  localparam int QUEUE_DEPTH = 2;

  // byte window
  localparam int WIN_DEPTH      = 7;
  localparam int FILL_W         = $clog2(WIN_DEPTH + 1);
  localparam int MPEG_HDR_BYTES = 4;
  localparam int ADTS_HDR_BYTES = 7;

  // frame length and the mpeg length datapath
  localparam int LEN_W       = 13;
  localparam int KBPS_W      = 9;
  localparam int MULT_W      = 9;
  localparam int PROD_W      = 16;
  localparam int QUO_W       = 11;
  localparam int RECIP_DIV   = 49;
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_49 = RECIP_W'((1 << RECIP_SHIFT) / RECIP_DIV);

  // mode register codes
  localparam logic MODE_MPEG = 1'b0;
  localparam logic MODE_ADTS = 1'b1;

  // header field codes
  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [2:0] MPEG_SYNC_HI = 3'b111;
  localparam logic [3:0] ADTS_SYNC_HI = 4'hF;
  localparam logic [1:0] LAYER_III    = 2'b01;
  localparam logic [1:0] VER_MPEG25   = 2'b00;
  localparam logic [1:0] VER_RSVD     = 2'b01;
  localparam logic [1:0] VER_MPEG2    = 2'b10;
  localparam logic [1:0] VER_MPEG1    = 2'b11;
  localparam logic [1:0] SRI_44K      = 2'b00;
  localparam logic [1:0] SRI_48K      = 2'b01;
  localparam logic [1:0] SRI_32K      = 2'b10;
  localparam logic [1:0] SRI_RSVD     = 2'b11;
  localparam logic [3:0] BRI_FREE     = 4'd0;
  localparam logic [3:0] BRI_BAD      = 4'd15;
  localparam logic [LEN_W-1:0] ADTS_MIN_LEN = LEN_W'(7);

  // one queued result: found flag plus what the length unit needs
  typedef struct packed {
    logic             found;
    logic             is_adts;
    logic [LEN_W-1:0] adts_len;
    logic [1:0]       ver;
    logic [3:0]       bri;
    logic [1:0]       sri;
    logic             pad;
  } frame_info_t;

  // bitrate in kbit/s from the bitrate index
  function automatic logic [KBPS_W-1:0] kbps_lookup(input logic mpeg1, input logic [3:0] bri);
    logic [KBPS_W-1:0] v;
    if (mpeg1) begin
      case (bri)
        4'd1:    v = 9'd32;
        4'd2:    v = 9'd40;
        4'd3:    v = 9'd48;
        4'd4:    v = 9'd56;
        4'd5:    v = 9'd64;
        4'd6:    v = 9'd80;
        4'd7:    v = 9'd96;
        4'd8:    v = 9'd112;
        4'd9:    v = 9'd128;
        4'd10:   v = 9'd160;
        4'd11:   v = 9'd192;
        4'd12:   v = 9'd224;
        4'd13:   v = 9'd256;
        4'd14:   v = 9'd320;
        default: v = 9'd0;
      endcase
    end else begin
      case (bri)
        4'd1:    v = 9'd8;
        4'd2:    v = 9'd16;
        4'd3:    v = 9'd24;
        4'd4:    v = 9'd32;
        4'd5:    v = 9'd40;
        4'd6:    v = 9'd48;
        4'd7:    v = 9'd56;
        4'd8:    v = 9'd64;
        4'd9:    v = 9'd80;
        4'd10:   v = 9'd96;
        4'd11:   v = 9'd112;
        4'd12:   v = 9'd128;
        4'd13:   v = 9'd144;
        4'd14:   v = 9'd160;
        default: v = 9'd0;
      endcase
    end
    return v;
  endfunction

  // coef * 1000 / rate reduces to kbps * mult, then /49, /2 or nothing
  function automatic logic [MULT_W-1:0] rate_mult(input logic [1:0] ver, input logic [1:0] sri);
    logic v25;
    logic [MULT_W-1:0] m;
    v25 = (ver == VER_MPEG25);
    case (sri)
      SRI_44K: m = v25 ? 9'd320 : 9'd160;
      SRI_48K: m = v25 ? 9'd6 : 9'd3;
      SRI_32K: m = 9'd9;
      default: m = 9'd0;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/afsf_front.sv
// ----------------------------------------------------------------------------
// afsf_front
// byte window, scan position and header detection; queues one job per result
// ----------------------------------------------------------------------------
`include "audio_frame_sync_finder_defines.svh"

module afsf_front #(
  parameter int OFFSET_WIDTH = afsf_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    mode,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              data_byte,
  input  logic                    first,
  input  logic                    last,
  input  logic [OFFSET_WIDTH-1:0] base_offset,
  input  logic                    full,
  output logic                    push,
  output afsf_pkg::frame_info_t   push_info,
  output logic [OFFSET_WIDTH-1:0] push_offset
);
  import afsf_pkg::*;

  localparam int MB = WIN_DEPTH - MPEG_HDR_BYTES;
  localparam int AB = WIN_DEPTH - ADTS_HDR_BYTES;

  logic [WIN_DEPTH-1:0][7:0] window;
  logic [FILL_W-1:0]         fill;
  logic [OFFSET_WIDTH-1:0]   position;
  logic                      match_done;

  logic [WIN_DEPTH-1:0][7:0] win_base, win_next;
  logic [FILL_W-1:0]         fill_base, fill_next;
  logic [OFFSET_WIDTH-1:0]   cur, position_next, hdr_offset;
  logic                      done_base, accept;
  logic                      mpeg_ok, adts_ok, hit;
  logic [1:0]                m_ver, m_layer, m_sri;
  logic [3:0]                m_bri;
  logic [LEN_W-1:0]          a_len;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // a new scan starts from a clear window at the given position
  always_comb begin
    win_base  = first ? '0 : window;
    fill_base = first ? '0 : fill;
    done_base = first ? 1'b0 : match_done;
    cur       = first ? base_offset : position;
    win_next  = {data_byte, win_base[WIN_DEPTH-1:1]};
    fill_next = (fill_base == FILL_W'(WIN_DEPTH)) ? fill_base : fill_base + FILL_W'(1);
    position_next = (&cur) ? cur : cur + OFFSET_WIDTH'(1);
  end

  // mpeg layer iii header ending at the newest byte
  always_comb begin
    m_ver   = win_next[MB+1][4:3];
    m_layer = win_next[MB+1][2:1];
    m_bri   = win_next[MB+2][7:4];
    m_sri   = win_next[MB+2][3:2];
    mpeg_ok = (fill_next >= FILL_W'(MPEG_HDR_BYTES))
              && (win_next[MB] == SYNC_BYTE)
              && (win_next[MB+1][7:5] == MPEG_SYNC_HI)
              && (m_layer == LAYER_III)
              && (m_ver != VER_RSVD)
              && (m_sri != SRI_RSVD)
              && (m_bri != BRI_FREE) && (m_bri != BRI_BAD);
  end

  // adts header ending at the newest byte
  always_comb begin
    a_len   = {win_next[AB+3][1:0], win_next[AB+4], win_next[AB+5][7:5]};
    adts_ok = (fill_next >= FILL_W'(ADTS_HDR_BYTES))
              && (win_next[AB] == SYNC_BYTE)
              && (win_next[AB+1][7:4] == ADTS_SYNC_HI)
              && (a_len >= ADTS_MIN_LEN);
  end

  assign hit = (mode == MODE_ADTS) ? adts_ok : mpeg_ok;
  assign hdr_offset = cur - ((mode == MODE_ADTS) ? OFFSET_WIDTH'(ADTS_HDR_BYTES - 1)
                                                 : OFFSET_WIDTH'(MPEG_HDR_BYTES - 1));

  // job for the length unit
  always_comb begin
    push              = accept && !done_base && (hit || last);
    push_info         = '0;
    push_offset       = '0;
    if (hit) begin
      push_info.found   = 1'b1;
      push_info.is_adts = (mode == MODE_ADTS);
      push_info.adts_len = a_len;
      push_info.ver     = m_ver;
      push_info.bri     = m_bri;
      push_info.sri     = m_sri;
      push_info.pad     = win_next[MB+2][1];
      push_offset       = hdr_offset;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      fill       <= '0;
      position   <= '0;
      match_done <= 1'b0;
    end else if (accept && !done_base) begin
      window     <= win_next;
      fill       <= fill_next;
      position   <= position_next;
      match_done <= hit || last;
    end
  end

  `AFSF_ASSERT_THEN(a_push_closes_scan, push, match_done, "job queued but scan left open")
  `AFSF_ASSERT_NOW(a_closed_scan_silent, !(accept && match_done && !first) || !push, "job queued from a closed scan")

endmodule

FILE: rtl/afsf_queue.sv
// ----------------------------------------------------------------------------
// afsf_queue
// short job queue between the scanner and the length unit
// ----------------------------------------------------------------------------
`include "audio_frame_sync_finder_defines.svh"

module afsf_queue #(
  parameter int OFFSET_WIDTH = afsf_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  afsf_pkg::frame_info_t   push_info,
  input  logic [OFFSET_WIDTH-1:0] push_offset,
  output logic                    full,
  output logic                    empty,
  input  logic                    pop,
  output afsf_pkg::frame_info_t   head_info,
  output logic [OFFSET_WIDTH-1:0] head_offset
);
  import afsf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_info_t             info_q [QUEUE_DEPTH];
  logic [OFFSET_WIDTH-1:0] off_q  [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr, rd_ptr;
  logic [CNT_W-1:0]        count;

  assign full        = (count == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count == '0);
  assign head_info   = info_q[rd_ptr];
  assign head_offset = off_q[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      info_q[wr_ptr] <= push_info;
      off_q[wr_ptr]  <= push_offset;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `AFSF_ASSERT_NOW(a_no_push_when_full, !(push && full), "push into a full job queue")
  `AFSF_ASSERT_NOW(a_no_pop_when_empty, !(pop && empty), "pop from an empty job queue")

endmodule

FILE: rtl/afsf_back.sv
// ----------------------------------------------------------------------------
// afsf_back
// frame length unit and output register
// ----------------------------------------------------------------------------
`include "audio_frame_sync_finder_defines.svh"

module afsf_back #(
  parameter int OFFSET_WIDTH = afsf_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_valid,
  output logic                                        pop,
  input  afsf_pkg::frame_info_t                       head_info,
  input  logic [OFFSET_WIDTH-1:0]                     head_offset,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [((OFFSET_WIDTH+20)/8)*8-1:0]          m_tdata,
  output logic                                        m_tuser
);
  import afsf_pkg::*;

  localparam int OUT_W = ((OFFSET_WIDTH + LEN_W + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIX  = 4'b1000
  } back_state_t;

  back_state_t             state, state_next;
  frame_info_t             job;
  logic [OFFSET_WIDTH-1:0] job_offset;
  logic [PROD_W-1:0]       prod;
  logic [QUO_W-1:0]        q_est;

  logic                    out_valid, out_found;
  logic [OFFSET_WIDTH-1:0] out_offset;
  logic [LEN_W-1:0]        out_length;

  logic [KBPS_W+MULT_W-1:0]   kbps_prod;
  logic [PROD_W+RECIP_W-1:0]  recip_prod;
  logic [PROD_W-1:0]          rem;
  logic [QUO_W-1:0]           q_fix;
  logic [LEN_W-1:0]           mpeg_base, mpeg_len, len_sel;
  logic                       out_free, load;

  assign out_free = !out_valid || m_tready;
  assign pop      = (state == ST_IDLE) && q_valid;
  assign load     = (state == ST_FIX) && out_free;

  // kbps times rate factor, then reciprocal multiply for the /49 cases
  assign kbps_prod  = (KBPS_W + MULT_W)'(kbps_lookup(job.ver == VER_MPEG1, job.bri))
                    * (KBPS_W + MULT_W)'(rate_mult(job.ver, job.sri));
  assign recip_prod = (PROD_W + RECIP_W)'(prod) * (PROD_W + RECIP_W)'(RECIP_49);

  // quotient correction and per-rate length selection
  always_comb begin
    rem   = prod - PROD_W'(q_est) * PROD_W'(RECIP_DIV);
    q_fix = (rem >= PROD_W'(RECIP_DIV)) ? q_est + QUO_W'(1) : q_est;
    case (job.sri)
      SRI_44K: mpeg_base = LEN_W'(q_fix);
      SRI_48K: mpeg_base = LEN_W'(prod);
      SRI_32K: mpeg_base = (job.ver == VER_MPEG25) ? LEN_W'(prod) : LEN_W'(prod >> 1);
      default: mpeg_base = '0;
    endcase
    mpeg_len = mpeg_base + LEN_W'(job.pad);
    if (!job.found) begin
      len_sel = '0;
    end else if (job.is_adts) begin
      len_sel = job.adts_len;
    end else begin
      len_sel = mpeg_len;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  state_next = ST_FIX;
      ST_FIX:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // job and datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      job        <= head_info;
      job_offset <= head_offset;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(kbps_prod);
    end
    if (state == ST_DIV) begin
      q_est <= recip_prod[RECIP_SHIFT +: QUO_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_found  <= job.found;
      out_offset <= job.found ? job_offset : '0;
      out_length <= len_sel;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = OUT_W'({out_length, out_offset});

  `AFSF_ASSERT_NOW(a_not_found_is_zero, !(out_valid && !out_found) || (out_length == '0 && out_offset == '0), "not-found result carries data")
  `AFSF_ASSERT_THEN(a_pop_starts_job, pop, state == ST_MUL, "popped job did not start")

endmodule

FILE: rtl/audio_frame_sync_finder.sv
// ----------------------------------------------------------------------------
// audio_frame_sync_finder
// finds the first mpeg layer iii or adts frame header in a byte stream
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one buffer byte per beat: tdata holds the byte and the base
//   offset, tuser starts a new scan at that offset, tlast ends the buffer.
//   cfg_* writes the mode bit (0 mpeg layer iii, 1 adts); the user writes it only while
//   no scan result is pending, which the block itself does not enforce; it is always ready.
//   m_* gives at most one result per scan: tuser is the found flag, tdata the
//   header offset and frame length, both zero when the buffer ended without
//   a header. Bytes after the result are dropped until the next scan start.
// Timing:
//   the scanner takes one byte per cycle while the job queue is not full; the byte that
//   completes the header (or the last byte) is queued as a job for the four-step length
//   unit (idle, mul, div, fix) behind a two-entry job queue, which loads the output register.
//   The length unit pops a new job only in idle, after it has loaded the previous result.
// Reset and stalls:
//   reset clears window, position, scan state, queue and mode; while m_tready
//   is low the result holds, the queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
module audio_frame_sync_finder #(
  parameter int OFFSET_WIDTH = afsf_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // byte stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((OFFSET_WIDTH+15)/8)*8-1:0]   s_tdata,  // data_byte, base_offset
  input  logic                                 s_tuser,  // first
  input  logic                                 s_tlast,  // last
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((OFFSET_WIDTH+20)/8)*8-1:0]   m_tdata,  // frame_offset, frame_length
  output logic                                 m_tuser,  // found
  // mode register
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data
);
  import afsf_pkg::*;

  logic                    mode;
  logic                    q_full, q_empty, q_push, q_pop;
  frame_info_t             push_info, head_info;
  logic [OFFSET_WIDTH-1:0] push_offset, head_offset;

  // mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MPEG;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // scanner
  afsf_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .data_byte   (s_tdata[7:0]),
    .first       (s_tuser),
    .last        (s_tlast),
    .base_offset (s_tdata[8 +: OFFSET_WIDTH]),
    .full        (q_full),
    .push        (q_push),
    .push_info   (push_info),
    .push_offset (push_offset)
  );

  // job queue
  afsf_queue #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (q_push),
    .push_info   (push_info),
    .push_offset (push_offset),
    .full        (q_full),
    .empty       (q_empty),
    .pop         (q_pop),
    .head_info   (head_info),
    .head_offset (head_offset)
  );

  // length unit and output register
  afsf_back #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_empty),
    .pop         (q_pop),
    .head_info   (head_info),
    .head_offset (head_offset),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

FILE: sim/audio_frame_sync_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_frame_sync_finder_test
// streams byte buffers into the frame sync finder in both modes, predicts the
// header offset, frame length or not-found report of every scan with a local
// model of the scanner, and checks each result beat against it under random
// source gaps and sink stalls, which one random run switches off
// ----------------------------------------------------------------------------
module audio_frame_sync_finder_test;
  import afsf_pkg::*;

  localparam int OFF_W = OFFSET_WIDTH_DEF;
  localparam int S_W = ((OFF_W + 15) / 8) * 8;
  localparam int M_W = ((OFF_W + 20) / 8) * 8;
  localparam logic [OFF_W-1:0] OFF_TOP = '1;
  // result passes the job queue and the length unit after its byte; leave margin on top
  localparam int DRAIN_CYCLES = 12;
  localparam int TIMEOUT_NS = 8_000_000;

  localparam int unsigned KBPS_MPEG1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
                                              192, 224, 256, 320, 0};
  localparam int unsigned KBPS_MPEG2 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96,
                                              112, 128, 144, 160, 0};
  localparam int unsigned RATE_MPEG1 [3] = '{44100, 48000, 32000};
  localparam int unsigned RATE_MPEG2 [3] = '{22050, 24000, 16000};
  localparam int unsigned RATE_MPEG25 [3] = '{11025, 12000, 8000};

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } frame_report_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [S_W-1:0] s_tdata = '0;   // data_byte, base_offset
  logic           s_tuser = 1'b0; // first
  logic           s_tlast = 1'b0; // last
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [M_W-1:0] m_tdata;        // frame_offset, frame_length
  logic           m_tuser;        // found
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_data = 1'b0;

  audio_frame_sync_finder #(
    .OFFSET_WIDTH(OFF_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // scanner model state
  logic [7:0]       hdr_window [WIN_DEPTH];
  int unsigned      window_bytes;
  logic [OFF_W-1:0] next_pos;
  bit               scan_closed;
  logic             scan_mode;
  int unsigned      scanned_bytes = 0;
  frame_report_t    pending_frames [$];

  int unsigned      fail_count = 0;
  bit               tx_idle_on = 1'b1;
  bit               rx_stall_on = 1'b1;
  int unsigned      rx_hold = 0;
  int unsigned      rx_pick;
  frame_report_t    want_frame;
  logic [OFF_W-1:0] got_offset;
  logic [LEN_W-1:0] got_length;

  // layer iii frame length of a header, 0 when the header is not valid
  function automatic int unsigned mpeg_frame_len(logic [7:0] b0, logic [7:0] b1,
                                                 logic [7:0] b2);
    logic [1:0]  ver;
    logic [3:0]  bri;
    logic [1:0]  sri;
    int unsigned rate;
    int unsigned kbps;
    int unsigned coef;
    int unsigned len;
    ver = b1[4:3];
    bri = b2[7:4];
    sri = b2[3:2];
    if (b0 != SYNC_BYTE || b1[7:5] != MPEG_SYNC_HI) return 0;
    if (b1[2:1] != LAYER_III || sri == SRI_RSVD || bri == BRI_FREE || bri == BRI_BAD ||
        ver == VER_RSVD) return 0;
    case (ver)
      VER_MPEG1: rate = RATE_MPEG1[sri];
      VER_MPEG2: rate = RATE_MPEG2[sri];
      default:   rate = RATE_MPEG25[sri];
    endcase
    kbps = (ver == VER_MPEG1) ? KBPS_MPEG1[bri] : KBPS_MPEG2[bri];
    coef = (ver == VER_MPEG1) ? 144 : 72;
    len = (coef * kbps * 1000) / rate + b2[1];
    return (len > 4) ? len : 0;
  endfunction

  // adts frame length field, 0 when the header is not valid
  function automatic int unsigned adts_frame_len(logic [7:0] b0, logic [7:0] b1,
                                                 logic [7:0] b3, logic [7:0] b4,
                                                 logic [7:0] b5);
    logic [LEN_W-1:0] len;
    if (b0 != SYNC_BYTE || b1[7:4] != ADTS_SYNC_HI) return 0;
    len = {b3[1:0], b4, b5[7:5]};
    return (len >= ADTS_MIN_LEN) ? len : 0;
  endfunction

  // advance the scanner model by one accepted byte
  function automatic void scan_byte(logic [7:0] b, bit is_first, bit is_last,
                                    logic [OFF_W-1:0] base);
    logic [OFF_W-1:0] cur;
    int unsigned      hdr_bytes;
    int unsigned      len;
    frame_report_t    rep;
    scanned_bytes++;
    if (is_first) begin
      foreach (hdr_window[i]) hdr_window[i] = '0;
      window_bytes = 0;
      scan_closed = 1'b0;
      next_pos = base;
    end
    if (scan_closed) return;
    cur = next_pos;
    if (next_pos != OFF_TOP) next_pos = next_pos + 1'b1;
    for (int i = 0; i < WIN_DEPTH - 1; i++) hdr_window[i] = hdr_window[i+1];
    hdr_window[WIN_DEPTH-1] = b;
    if (window_bytes < WIN_DEPTH) window_bytes++;
    hdr_bytes = (scan_mode == MODE_ADTS) ? ADTS_HDR_BYTES : MPEG_HDR_BYTES;
    len = 0;
    if (window_bytes >= hdr_bytes) begin
      if (scan_mode == MODE_ADTS)
        len = adts_frame_len(hdr_window[0], hdr_window[1], hdr_window[3], hdr_window[4],
                             hdr_window[5]);
      else
        len = mpeg_frame_len(hdr_window[3], hdr_window[4], hdr_window[5]);
    end
    if (len != 0) begin
      scan_closed = 1'b1;
      rep.found = 1'b1;
      rep.offset = cur - OFF_W'(hdr_bytes - 1);
      rep.length = len[LEN_W-1:0];
      pending_frames.push_back(rep);
    end else if (is_last) begin
      scan_closed = 1'b1;
      rep = '0;
      pending_frames.push_back(rep);
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // model follows mode writes and accepted bytes
  always @(posedge clk) begin
    if (rst) begin
      foreach (hdr_window[i]) hdr_window[i] = '0;
      window_bytes = 0;
      next_pos = '0;
      scan_closed = 1'b0;
      scan_mode = MODE_MPEG;
    end else begin
      if (cfg_valid && cfg_ready) scan_mode = cfg_data;
      if (s_tvalid && s_tready)
        scan_byte(s_tdata[7:0], s_tuser, s_tlast, s_tdata[8 +: OFF_W]);
    end
  end

  // compare each result beat with the oldest pending report
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_offset = m_tdata[OFF_W-1:0];
      got_length = m_tdata[OFF_W +: LEN_W];
      if (pending_frames.size() == 0) begin
        note_failure($sformatf("%0t: unexpected result found=%0b offset=%h length=%0d",
                               $time, m_tuser, got_offset, got_length));
      end else begin
        want_frame = pending_frames.pop_front();
        if (m_tuser !== want_frame.found)
          note_failure($sformatf("%0t: found expected %0b got %0b", $time,
                                 want_frame.found, m_tuser));
        if (got_offset !== want_frame.offset)
          note_failure($sformatf("%0t: frame_offset expected %h got %h", $time,
                                 want_frame.offset, got_offset));
        if (got_length !== want_frame.length)
          note_failure($sformatf("%0t: frame_length expected %0d got %0d", $time,
                                 want_frame.length, got_length));
      end
    end
  end

  // sink stalls: mostly short, a few long
  always @(negedge clk) begin
    if (!rx_stall_on) begin
      m_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 15) begin
        rx_hold = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else if (rx_pick < 18) begin
        rx_hold = $urandom_range(10, 40);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one byte beat; valid stays up so back-to-back beats need no gap
  task automatic send_byte(input logic [7:0] b, input bit is_first, input bit is_last,
                           input logic [OFF_W-1:0] base);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= S_W'({base, b});
    s_tuser <= is_first;
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid, wait for every pending report and the pipeline tail
  task automatic wait_drained();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic test_mpeg_directed();
    // no scan start since reset: mpeg1 128 kbit/s 44.1 khz header at position zero
    send_byte(8'hFF, 1'b0, 1'b0, '0);
    send_byte(8'hFB, 1'b0, 1'b0, '0);
    send_byte(8'h90, 1'b0, 1'b0, '0);
    send_byte(8'h64, 1'b0, 1'b0, '0);
    // scan already closed: a marked last byte is dropped
    send_byte(8'hFF, 1'b0, 1'b1, OFF_TOP);
    // mpeg 2.5 160 kbit/s 8 khz header whose last byte also ends the buffer
    send_byte(8'hFF, 1'b1, 1'b0, OFF_W'(24'h000011));
    send_byte(8'hE2, 1'b0, 1'b0, '0);
    send_byte(8'hE8, 1'b0, 1'b0, '0);
    send_byte(8'h00, 1'b0, 1'b1, '0);
    // buffer ends before any header, scan starts at the top position
    send_byte(8'hFF, 1'b1, 1'b0, OFF_TOP);
    send_byte(8'hFF, 1'b0, 1'b1, '0);
    // position saturates while the header is still arriving
    send_byte(8'hAA, 1'b1, 1'b0, OFF_TOP - 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0, '0);
    send_byte(8'hF3, 1'b0, 1'b0, '0);
    send_byte(8'h14, 1'b0, 1'b0, '0);
  endtask

  task automatic test_mode_switch_mid_scan();
    // bytes scanned as mpeg, header completes as adts with the window kept
    send_byte(8'hFF, 1'b1, 1'b0, OFF_W'(24'h00ABCD));
    send_byte(8'hF9, 1'b0, 1'b0, '0);
    send_byte(8'h50, 1'b0, 1'b0, '0);
    send_byte(8'h83, 1'b0, 1'b0, '0);
    write_mode(MODE_ADTS);
    // longest adts frame
    send_byte(8'hFF, 1'b0, 1'b0, '0);
    send_byte(8'hE0, 1'b0, 1'b0, '0);
    send_byte(8'h00, 1'b0, 1'b0, '0);
  endtask

  task automatic test_adts_directed();
    // length field of 6 is rejected, buffer ends unmatched
    send_byte(8'hFF, 1'b1, 1'b0, '0);
    send_byte(8'hF1, 1'b0, 1'b0, '0);
    send_byte(8'h00, 1'b0, 1'b0, '0);
    send_byte(8'h00, 1'b0, 1'b0, '0);
    send_byte(8'h00, 1'b0, 1'b0, '0);
    send_byte(8'hC0, 1'b0, 1'b0, '0);
    send_byte(8'h00, 1'b0, 1'b1, '0);
  endtask

  // filler, usually a header in the current mode (mostly well formed), more filler
  task automatic send_random_scan();
    logic [7:0]       bytes_q [$];
    logic [7:0]       hdr [WIN_DEPTH];
    logic [LEN_W-1:0] flen;
    logic [1:0]       ver;
    logic [3:0]       bri;
    logic [1:0]       sri;
    logic [OFF_W-1:0] base;
    int unsigned      n;
    int unsigned      pick;
    bit               use_first;
    bit               has_last;
    bit               noisy;
    bit               good;
    bit               is_first;
    bit               is_last;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
    repeat (n) bytes_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) begin
      good = ($urandom_range(0, 3) != 0);
      foreach (hdr[i]) hdr[i] = 8'($urandom_range(0, 255));
      hdr[0] = SYNC_BYTE;
      if (scan_mode == MODE_MPEG) begin
        if (good) begin
          pick = $urandom_range(0, 2);
          ver = (pick == 0) ? VER_MPEG25 : (pick == 1) ? VER_MPEG2 : VER_MPEG1;
          bri = 4'($urandom_range(1, 14));
          sri = 2'($urandom_range(0, 2));
          hdr[1] = {MPEG_SYNC_HI, ver, LAYER_III, hdr[1][0]};
          hdr[2] = {bri, sri, hdr[2][1:0]};
        end else if ($urandom_range(0, 1) != 0) begin
          hdr[1][7:5] = MPEG_SYNC_HI;
        end
        n = MPEG_HDR_BYTES;
      end else begin
        flen = good ? LEN_W'($urandom_range(7, 8191)) : LEN_W'($urandom_range(0, 8));
        if (good || $urandom_range(0, 1) != 0) hdr[1][7:4] = ADTS_SYNC_HI;
        hdr[3][1:0] = flen[12:11];
        hdr[4] = flen[10:3];
        hdr[5][7:5] = flen[2:0];
        n = ADTS_HDR_BYTES;
      end
      for (int i = 0; i < n; i++) bytes_q.push_back(hdr[i]);
    end
    n = $urandom_range(0, 6);
    repeat (n) bytes_q.push_back(8'($urandom_range(0, 255)));
    if (bytes_q.size() == 0) bytes_q.push_back(8'($urandom_range(0, 255)));

    use_first = ($urandom_range(0, 9) != 0);
    has_last = ($urandom_range(0, 4) != 0);
    noisy = ($urandom_range(0, 9) == 0);
    pick = $urandom_range(0, 9);
    if (pick == 0) base = '0;
    else if (pick == 1) base = OFF_TOP - OFF_W'($urandom_range(0, 8));
    else base = OFF_W'($urandom);

    foreach (bytes_q[i]) begin
      is_first = use_first && (i == 0);
      is_last = has_last && (i == bytes_q.size() - 1);
      if (noisy) begin
        is_first |= ($urandom_range(0, 19) == 0);
        is_last |= ($urandom_range(0, 19) == 0);
      end
      send_byte(bytes_q[i], is_first, is_last, (i == 0) ? base : OFF_W'($urandom));
    end
  endtask

  task automatic test_random_scans(input logic m, input int unsigned n_bytes,
                                   input bit idle_on);
    int unsigned stop_at;
    int unsigned scans;
    write_mode(m);
    tx_idle_on = idle_on;
    rx_stall_on = idle_on;
    stop_at = scanned_bytes + n_bytes;
    scans = 0;
    while (scanned_bytes < stop_at) begin
      send_random_scan();
      scans++;
      // hold off the source until every result is out
      if (scans % 25 == 0) wait_drained();
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_mpeg_directed();
    test_mode_switch_mid_scan();
    test_adts_directed();
    test_random_scans(MODE_MPEG, 400, 1'b1);
    test_random_scans(MODE_ADTS, 150, 1'b0);
    test_random_scans(MODE_ADTS, 350, 1'b1);
    test_random_scans(MODE_MPEG, 450, 1'b1);
    wait_drained();
    if (fail_count == 0 && pending_frames.size() == 0) begin
      $display("audio_frame_sync_finder_test: PASS");
    end else begin
      $display("audio_frame_sync_finder_test: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("audio_frame_sync_finder_test: FAIL");
    $finish;
  end

endmodule
